/* rtl/sprite_blit_alpha1_rgb565_defines.svh */
// Assertion macros used by the sprite blitter back end.
`ifndef SPRITE_BLIT_ALPHA1_RGB565_DEFINES_SVH
`define SPRITE_BLIT_ALPHA1_RGB565_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that is switched off while reset is high.
`define SBB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also applies while reset is high.
`define SBB_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBB_ASSERT(lbl, clk, rst, prop, msg)
`define SBB_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

/* rtl/sbb_pkg.sv */
// Types and constants shared by the sprite blitter modules.
package sbb_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_FB_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FB_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IMG_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_IMG_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_MODE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_IS_RGB565  = 3'd7;

   // front-to-back queue depth
   localparam int QDEPTH = 2;

   // pixels issued per byte at most
   localparam int NPIX_MAX = 8;

   // bit buffer geometry
   localparam int BITS_W = 24;
   localparam int CNT_W  = 5;
   localparam logic [CNT_W-1:0] CNT_MERGE_CAP  = 5'd16;
   localparam logic [CNT_W-1:0] BYTE_BITS      = 5'd8;
   localparam logic [CNT_W-1:0] COLOR_BITS     = 5'd16;
   localparam logic [CNT_W-1:0] OPAQUE_BITS    = 5'd17;
   localparam logic [CNT_W-1:0] TRANSP_BITS    = 5'd1;

   typedef struct packed {
      logic [10:0] fb_width;
      logic [10:0] fb_height;
      logic [9:0]  origin_x;
      logic [9:0]  origin_y;
      logic [10:0] img_width;
      logic [10:0] img_height;
      logic        alpha_mode;
      logic        image_is_rgb565;
   } sbb_cfg_type;

   localparam sbb_cfg_type CFG_RESET = '{
      fb_width:        11'd320,
      fb_height:       11'd240,
      origin_x:        10'd0,
      origin_y:        10'd0,
      img_width:       11'd0,
      img_height:      11'd0,
      alpha_mode:      1'b0,
      image_is_rgb565: 1'b1
   };

   // queued item: byte plus its classification
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       drop;
   } sbb_entry_type;

endpackage

/* rtl/sbb_front.sv */
// Input side: accepts bytes, classifies them and queues them for the back end.
module sbb_front import sbb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  sbb_cfg_type   cfg,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_data_byte,
   input  logic          req_first_byte,
   output logic          q_valid,
   output sbb_entry_type q_entry,
   input  logic          q_pop
);

   localparam int QPW = $clog2(QDEPTH);
   localparam int QCW = $clog2(QDEPTH + 1);

   sbb_entry_type      slot_ff [QDEPTH];
   logic [QPW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]     count_ff, count_in;
   logic               push;
   logic               pop;
   sbb_entry_type      new_entry;

   assign req_stall = (count_ff == QCW'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = slot_ff[rd_ptr_ff];

   // user keeps config static while items are in flight (unenforced); drop set here
   always_comb begin
      new_entry.data_byte  = req_data_byte;
      new_entry.first_byte = req_first_byte;
      new_entry.drop       = !cfg.image_is_rgb565 || (cfg.img_width == '0) ||
                             (cfg.img_height == '0);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

/* rtl/sbb_back.sv */
// Back end: bitstream decode, pixel placement and the result register.
`include "sprite_blit_alpha1_rgb565_defines.svh"
module sbb_back import sbb_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  sbb_cfg_type   cfg,
   input  logic          q_valid,
   input  sbb_entry_type q_entry,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [19:0]   rsp_pixel_address,
   output logic [15:0]   rsp_pixel_color,
   output logic          rsp_write_enable,
   output logic          rsp_out_of_range,
   output logic          rsp_last_pixel
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int XW  = ((CW > 10) ? CW : 10) + 1;
   localparam int YW  = ((RW > 10) ? RW : 10) + 1;
   localparam int NPW = $clog2(NPIX_MAX);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EMIT = 1'b1;

   logic                 state_ff, state_in;
   logic [BITS_W-1:0]    bits_ff, bits_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]        column_ff, column_in;
   logic [RW-1:0]        row_ff, row_in;
   logic                 done_ff, done_in;
   logic [NPW-1:0]       npix_ff, npix_in;

   logic                 rsp_valid_ff;
   logic [19:0]          addr_ff;
   logic [15:0]          color_ff;
   logic                 we_ff, oor_ff, last_ff;

   logic [CW:0]          w_sat;
   logic [RW:0]          h_sat;
   logic [BITS_W-1:0]    base_bits, merged;
   logic [CNT_W-1:0]     base_cnt, eff_cnt;
   logic                 base_done;
   logic                 avail, opaque;
   logic [CNT_W-1:0]     consume;
   logic [15:0]          color;
   logic [XW-1:0]        fx;
   logic [YW-1:0]        fy;
   logic                 oor;
   logic [CW:0]          col_nx;
   logic [RW:0]          row_nx;
   logic                 last;
   logic [21:0]          prod, addr_full;
   logic [19:0]          addr;
   logic                 out_free;
   logic                 emit;

   assign w_sat = ({2'b00, cfg.img_width} > 13'(MAX_WIDTH)) ? (CW+1)'(MAX_WIDTH)
                                                            : (CW+1)'(cfg.img_width);
   assign h_sat = ({2'b00, cfg.img_height} > 13'(MAX_HEIGHT)) ? (RW+1)'(MAX_HEIGHT)
                                                              : (RW+1)'(cfg.img_height);

   // merge of a new byte, after an optional restart
   assign base_bits = q_entry.first_byte ? '0 : bits_ff;
   assign base_cnt  = q_entry.first_byte ? '0 : cnt_ff;
   assign base_done = q_entry.first_byte ? 1'b0 : done_ff;
   assign eff_cnt   = (base_cnt > CNT_MERGE_CAP) ? CNT_MERGE_CAP : base_cnt;
   assign merged    = base_bits | (BITS_W'(q_entry.data_byte) << eff_cnt);

   // next pixel out of the bit buffer
   always_comb begin
      if (cfg.alpha_mode) begin
         opaque  = bits_ff[0];
         consume = bits_ff[0] ? OPAQUE_BITS : TRANSP_BITS;
         color   = bits_ff[0] ? bits_ff[16:1] : 16'h0000;
         avail   = (cnt_ff != '0) && (!bits_ff[0] || (cnt_ff >= OPAQUE_BITS));
      end else begin
         opaque  = 1'b1;
         consume = COLOR_BITS;
         color   = bits_ff[15:0];
         avail   = (cnt_ff >= COLOR_BITS);
      end
   end

   // placement
   assign fx        = XW'(cfg.origin_x) + XW'(column_ff);
   assign fy        = YW'(cfg.origin_y) + YW'(row_ff);
   assign oor       = (fx >= XW'(cfg.fb_width)) || (fy >= YW'(cfg.fb_height));
   assign col_nx    = (CW+1)'(column_ff) + 1'b1;
   assign row_nx    = (RW+1)'(row_ff) + 1'b1;
   assign last      = (row_nx >= h_sat) && (col_nx >= w_sat);
   assign prod      = 22'(fy[10:0]) * 22'(cfg.fb_width);
   assign addr_full = prod + 22'(fx[10:0]);
   assign addr      = oor ? 20'd0 : addr_full[19:0];

   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      bits_in   = bits_ff;
      cnt_in    = cnt_ff;
      column_in = column_ff;
      row_in    = row_ff;
      done_in   = done_ff;
      npix_in   = npix_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.first_byte) begin
                  bits_in   = '0;
                  cnt_in    = '0;
                  column_in = '0;
                  row_in    = '0;
                  done_in   = 1'b0;
               end
               if (!q_entry.drop && !base_done) begin
                  bits_in  = merged;
                  cnt_in   = eff_cnt + BYTE_BITS;
                  npix_in  = '0;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (!avail) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               emit    = 1'b1;
               bits_in = bits_ff >> consume;
               cnt_in  = cnt_ff - consume;
               npix_in = npix_ff + 1'b1;
               if (last) begin
                  // image finished: leftover bits are dropped
                  done_in  = 1'b1;
                  bits_in  = '0;
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  if (col_nx >= w_sat) begin
                     column_in = '0;
                     row_in    = RW'(row_nx);
                  end else begin
                     column_in = CW'(col_nx);
                  end
                  if (npix_ff == NPW'(NPIX_MAX - 1)) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bits_ff      <= '0;
         cnt_ff       <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         done_ff      <= 1'b0;
         npix_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bits_ff   <= bits_in;
         cnt_ff    <= cnt_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         done_ff   <= done_in;
         npix_ff   <= npix_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         addr_ff  <= addr;
         color_ff <= color;
         we_ff    <= opaque && !oor;
         oor_ff   <= oor;
         last_ff  <= last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_pixel_color   = color_ff;
   assign rsp_write_enable  = we_ff;
   assign rsp_out_of_range  = oor_ff;
   assign rsp_last_pixel    = last_ff;

   `SBB_ASSERT(a_cnt_bound, clock, reset, (cnt_ff <= 5'd24), "bit count above buffer size")
   `SBB_ASSERT(a_emit_not_done, clock, reset, ((state_ff == S_EMIT) |-> !done_ff), "decoding after image end")
   `SBB_ASSERT(a_last_sets_done, clock, reset, ((emit && last) |=> (done_ff && (cnt_ff == '0))), "last pixel did not finish image")
   `SBB_ASSERT_NORST(a_reset_clears_out, clock, (reset |=> !rsp_valid_ff), "result valid after reset")

endmodule

/* rtl/sprite_blit_alpha1_rgb565.sv */
// Sprite blitter top: RGB565 image with optional 1-bit alpha to framebuffer pixel writes.
// A byte is written into the input queue, then popped by the back end and, unless dropped,
// merged into the bit buffer; each pixel it completes (0 to 8) is then emitted to the result
// register when the output is free, and the decoder goes idle once the buffer runs short or
// after the byte's eighth pixel or the image's last.
// Synchronous active-high reset clears config to defaults and empties queue and decoder.
module sprite_blit_alpha1_rgb565 import sbb_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_first_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [19:0]           rsp_pixel_address,
   output logic [15:0]           rsp_pixel_color,
   output logic                  rsp_write_enable,
   output logic                  rsp_out_of_range,
   output logic                  rsp_last_pixel
);

   sbb_cfg_type   cfg_ff, cfg_in;
   logic          q_valid;
   logic          q_pop;
   sbb_entry_type q_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_FB_WIDTH:   cfg_in.fb_width        = csr_wdata;
            REG_FB_HEIGHT:  cfg_in.fb_height       = csr_wdata;
            REG_ORIGIN_X:   cfg_in.origin_x        = csr_wdata[9:0];
            REG_ORIGIN_Y:   cfg_in.origin_y        = csr_wdata[9:0];
            REG_IMG_WIDTH:  cfg_in.img_width       = csr_wdata;
            REG_IMG_HEIGHT: cfg_in.img_height      = csr_wdata;
            REG_ALPHA_MODE: cfg_in.alpha_mode      = csr_wdata[0];
            REG_IS_RGB565:  cfg_in.image_is_rgb565 = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop)
   );

   sbb_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_out_of_range  (rsp_out_of_range),
      .rsp_last_pixel    (rsp_last_pixel)
   );

endmodule
